FILE: hw/rtl/i2c_clock_divider_search_macros.svh
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_macros.svh
// Assertion macros shared by the divider search RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define I2C_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/i2cds_pkg.sv
// ----------------------------------------------------------------------------
// i2cds_pkg
// Constants, divider tables and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cds_pkg;

  localparam int TableSize    = 50;
  localparam int TableEntries = 50;
  localparam int Limit        = (TableEntries > TableSize) ? TableSize : TableEntries;
  localparam int MultCount    = 3;
  localparam int IdxW         = $clog2(TableSize);
  localparam int SclW         = 12;
  localparam int DivW         = SclW + 2;
  localparam int DataW        = 32;
  localparam int CntW         = $clog2(DataW);

  localparam logic [5:0] DivCodeTab [TableSize] = '{
    6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h09, 6'h06, 6'h0a, 6'h07,
    6'h0c, 6'h0d, 6'h0e, 6'h12, 6'h0f, 6'h13, 6'h14, 6'h15, 6'h19, 6'h16,
    6'h1a, 6'h17, 6'h1c, 6'h1d, 6'h1e, 6'h22, 6'h1f, 6'h23, 6'h24, 6'h25,
    6'h26, 6'h2a, 6'h27, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h32, 6'h2f, 6'h33,
    6'h34, 6'h35, 6'h36, 6'h3a, 6'h37, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f
  };

  localparam logic [SclW-1:0] SclDivTab [TableSize] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,
    12'd30,   12'd32,   12'd34,   12'd36,   12'd40,
    12'd44,   12'd48,   12'd56,   12'd64,   12'd68,
    12'd72,   12'd80,   12'd88,   12'd96,   12'd104,
    12'd112,  12'd128,  12'd144,  12'd160,  12'd192,
    12'd224,  12'd240,  12'd256,  12'd288,  12'd320,
    12'd384,  12'd448,  12'd480,  12'd512,  12'd576,
    12'd640,  12'd768,  12'd896,  12'd960,  12'd1024,
    12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920,
    12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef struct packed {
    logic            load;       // capture inputs, clear best candidate
    logic            div_start;  // set up divider for candidate (mult, idx)
    logic            div_step;   // one quotient bit
    logic            eval;       // compare quotient against best so far
    logic [1:0]      mult;
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;              // current step produces the last quotient bit
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cds_dp.sv
// ----------------------------------------------------------------------------
// i2cds_dp
// Datapath: input registers, bit-serial restoring divider, best-candidate keep.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cds_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire i2cds_pkg::dp_cmd_t         cmd,
  output i2cds_pkg::dp_stat_t             stat,
  input  wire logic [31:0]                bus_clock_hz,
  input  wire logic [31:0]                target_hz,
  output logic [7:0]                      freq_reg_value,
  output logic [1:0]                      mult_code,
  output logic [5:0]                      divider_code,
  output logic [31:0]                     achieved_hz,
  output logic                            found
);
  import i2cds_pkg::*;

  logic [DataW-1:0] bus_q;
  logic [DataW-1:0] target_q;
  logic [DataW-1:0] work;       // dividend shifts out, quotient shifts in
  logic [DivW-1:0]  rem;
  logic [DivW-1:0]  divisor;
  logic [CntW-1:0]  cnt;
  logic [1:0]       cur_mult;
  logic [5:0]       cur_code;
  logic [DataW-1:0] best_rate;
  logic [1:0]       best_mult;
  logic [5:0]       best_code;
  logic             best_found;

  logic [DivW:0]    rem_sh;
  logic             ge;
  logic [DivW:0]    rem_sub;
  logic             take;

  always_comb begin
    rem_sh  = {rem, work[DataW-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
    // rate <= target and not below the best so far (later candidate wins a tie)
    take    = (work <= target_q) && (!best_found || (work >= best_rate));
  end

  assign stat.div_last = (cnt == CntW'(DataW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bus_q    <= bus_clock_hz;
      target_q <= target_hz;
    end
    if (cmd.div_start) begin
      work     <= bus_q;
      rem      <= '0;
      divisor  <= DivW'({2'b00, SclDivTab[cmd.idx]} << cmd.mult);
      cnt      <= '0;
      cur_mult <= cmd.mult;
      cur_code <= DivCodeTab[cmd.idx];
    end else if (cmd.div_step) begin
      work <= {work[DataW-2:0], ge};
      rem  <= ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
      cnt  <= cnt + CntW'(1);
    end
    if (cmd.load) begin
      best_rate <= '0;
      best_mult <= '0;
      best_code <= '0;
    end else if (cmd.eval && take) begin
      best_rate <= work;
      best_mult <= cur_mult;
      best_code <= cur_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.load) begin
      best_found <= 1'b0;
    end else if (cmd.eval && take) begin
      best_found <= 1'b1;
    end
  end

  assign freq_reg_value = {best_mult, best_code};
  assign mult_code      = best_mult;
  assign divider_code   = best_code;
  assign achieved_hz    = best_rate;
  assign found          = best_found;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cds_ctrl.sv
// ----------------------------------------------------------------------------
// i2cds_ctrl
// Controller: walks multipliers and table entries, sequences the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output i2cds_pkg::dp_cmd_t        cmd,
  input  wire i2cds_pkg::dp_stat_t  stat
);
  import i2cds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

  state_t          state;
  logic [1:0]      mult;
  logic [IdxW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mult  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mult  <= '0;
            idx   <= '0;
            state <= S_START;
          end
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) state <= S_EVAL;
        end
        S_EVAL: begin
          if (idx == IdxW'(Limit - 1)) begin
            idx <= '0;
            if (mult == 2'(MultCount - 1)) begin
              state <= S_DONE;
            end else begin
              mult  <= mult + 2'd1;
              state <= S_START;
            end
          end else begin
            idx   <= idx + IdxW'(1);
            state <= S_START;
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_DONE);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.div_start = (state == S_START);
    cmd.div_step  = (state == S_DIV);
    cmd.eval      = (state == S_EVAL);
    cmd.mult      = mult;
    cmd.idx       = idx;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_clock_divider_search.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_search
// Finds the serial clock divider setting closest to, not above, a target rate.
// ----------------------------------------------------------------------------
// One transaction in, one out. Each of the 150 candidates (x1, x2, x4 times the
// 50-entry divisor table) goes through a set-up state, the bit-serial divider
// (one quotient bit per cycle) and a compare state. The controller returns to
// idle after the result is taken. One search at a time;
// in_ready is low while a search runs or a result waits.
`default_nettype none

`include "i2c_clock_divider_search_macros.svh"

module i2c_clock_divider_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] bus_clock_hz,
  input  wire logic [31:0] target_hz,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       freq_reg_value,
  output logic [1:0]       mult_code,
  output logic [5:0]       divider_code,
  output logic [31:0]      achieved_hz,
  output logic             found
);
  import i2cds_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  i2cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  i2cds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .bus_clock_hz   (bus_clock_hz),
    .target_hz      (target_hz),
    .freq_reg_value (freq_reg_value),
    .mult_code      (mult_code),
    .divider_code   (divider_code),
    .achieved_hz    (achieved_hz),
    .found          (found)
  );

  `ASSERT_SAME(a_idle_excl, in_ready, !out_valid)
  `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready && !out_valid)
  `ASSERT_SAME(a_none_zero, out_valid && !found, freq_reg_value == 8'd0 && achieved_hz == 32'd0)
  `ASSERT_SAME(a_mult_range, out_valid, mult_code != 2'd3)

endmodule

`default_nettype wire

FILE: dv/i2c_clock_divider_search_tb.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_tb
// Drives bus clock / target rate requests into the divider search and checks
// every returned divider choice against an in-bench search over all 150
// candidates. Directed corner requests come first, then random ones, under
// three mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDividers = 50;
  localparam int NumMults    = 3;
  localparam int RandomReqs  = 100;

  localparam bit [11:0] SclDivisors [NumDividers] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd32,   12'd34,
    12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd64,   12'd68,   12'd72,
    12'd80,   12'd88,   12'd96,   12'd104,  12'd112,  12'd128,  12'd144,  12'd160,
    12'd192,  12'd224,  12'd240,  12'd256,  12'd288,  12'd320,  12'd384,  12'd448,
    12'd480,  12'd512,  12'd576,  12'd640,  12'd768,  12'd896,  12'd960,  12'd1024,
    12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920, 12'd2048, 12'd2304, 12'd2560,
    12'd3072, 12'd3840
  };

  localparam bit [5:0] DividerCodes [NumDividers] = '{
    6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h09, 6'h06, 6'h0a, 6'h07,
    6'h0c, 6'h0d, 6'h0e, 6'h12, 6'h0f, 6'h13, 6'h14, 6'h15, 6'h19, 6'h16,
    6'h1a, 6'h17, 6'h1c, 6'h1d, 6'h1e, 6'h22, 6'h1f, 6'h23, 6'h24, 6'h25,
    6'h26, 6'h2a, 6'h27, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h32, 6'h2f, 6'h33,
    6'h34, 6'h35, 6'h36, 6'h3a, 6'h37, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f
  };

  typedef struct packed {
    logic [7:0]  freq_reg;
    logic [1:0]  mult;
    logic [5:0]  code;
    logic [31:0] rate;
    logic        found;
  } divider_choice_t;

  class divider_scoreboard;
    divider_choice_t expected_choices[$];
    int unsigned     mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exhaustive search: x1/x2/x4 outer, table order inner, later wins ties.
    function divider_choice_t best_divider(bit [31:0] bus_hz, bit [31:0] want_hz);
      divider_choice_t best;
      bit [31:0]       divisor;
      bit [31:0]       rate;
      best = '0;
      for (int m = 0; m < NumMults; m++) begin
        for (int i = 0; i < NumDividers; i++) begin
          divisor = (32'd1 << m) * SclDivisors[i];
          rate    = bus_hz / divisor;
          if (rate <= want_hz &&
              (!best.found || (want_hz - rate) <= (want_hz - best.rate))) begin
            best.found = 1'b1;
            best.rate  = rate;
            best.mult  = m[1:0];
            best.code  = DividerCodes[i];
          end
        end
      end
      best.freq_reg = {best.mult, best.code};
      return best;
    endfunction

    function void note_request(bit [31:0] bus_hz, bit [31:0] want_hz);
      expected_choices.push_back(best_divider(bus_hz, want_hz));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(divider_choice_t got);
      divider_choice_t want;
      if (expected_choices.size() == 0) begin
        $display("%0t: freq_reg_value expected no transaction, got 0x%0h",
                 $time, got.freq_reg);
        mismatches++;
        return;
      end
      want = expected_choices.pop_front();
      compare_field("freq_reg_value", 32'(want.freq_reg), 32'(got.freq_reg));
      compare_field("mult_code", 32'(want.mult), 32'(got.mult));
      compare_field("divider_code", 32'(want.code), 32'(got.code));
      compare_field("achieved_hz", want.rate, got.rate);
      compare_field("found", 32'(want.found), 32'(got.found));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] bus_clock_hz = '0;
  logic [31:0] target_hz = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  freq_reg_value;
  logic [1:0]  mult_code;
  logic [5:0]  divider_code;
  logic [31:0] achieved_hz;
  logic        found;

  int unsigned sender_gap_pct = 10;
  int unsigned recv_stall_pct = 46;

  divider_scoreboard sb;

  i2c_clock_divider_search dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .bus_clock_hz   (bus_clock_hz),
    .target_hz      (target_hz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .freq_reg_value (freq_reg_value),
    .mult_code      (mult_code),
    .divider_code   (divider_code),
    .achieved_hz    (achieved_hz),
    .found          (found)
  );

  always #4 clk = ~clk;

  // Valid is lowered only when a gap is actually taken, so back-to-back
  // requests never see a low and a high in the same step.
  task automatic send_request(bit [31:0] bus_hz, bit [31:0] want_hz);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      if (!lowered) begin
        in_valid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    bus_clock_hz <= bus_hz;
    target_hz    <= want_hz;
    do @(posedge clk); while (!in_ready);
    sb.note_request(bus_hz, want_hz);
  endtask

  task automatic send_random_request();
    bit [31:0]   bus_hz;
    bit [31:0]   want_hz;
    int unsigned pick;
    int unsigned m;
    int unsigned i;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      // realistic bus clock, target near some achievable rate
      bus_hz  = $urandom_range(1_000_000, 250_000_000);
      want_hz = bus_hz / $urandom_range(20, 15360);
      want_hz = want_hz + $urandom_range(0, 2) - 1;
    end else if (pick == 6) begin
      // target sits exactly on one candidate rate
      bus_hz  = $urandom;
      m       = $urandom_range(0, NumMults - 1);
      i       = $urandom_range(0, NumDividers - 1);
      want_hz = bus_hz / ((32'd1 << m) * SclDivisors[i]);
    end else if (pick == 9) begin
      bus_hz  = $urandom;
      want_hz = $urandom_range(0, 1000);
    end else begin
      bus_hz  = $urandom;
      want_hz = $urandom;
    end
    send_request(bus_hz, want_hz);
  endtask

  // Result side: sample at the edge, then pick next cycle's ready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_result('{freq_reg_value, mult_code, divider_code, achieved_hz, found});
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(32'd100_000_000, 32'd100_000);
    send_request(32'd48_000_000, 32'd400_000);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'hffff_ffff, 32'd1);             // nothing fits
    send_request(32'd0, 32'd0);                     // zero bus clock, zero target
    send_request(32'd0, 32'hffff_ffff);
    send_request(32'd1, 32'd0);
    send_request(32'd10_000, 32'd0);                // only the slowest dividers fit
    send_request(32'd1, 32'd1);
    send_request(32'd20, 32'd1);
    send_request(32'd8_000, 32'd200);               // x1/40 ties x2/20, x2 wins
    send_request(32'd15_360, 32'd1);                // tie among five x4 entries
    send_request(32'hffff_ffff, 32'h8000_0000);
    send_request(32'h8000_0000, 32'h7fff_ffff);
    send_request(32'h5555_5555, 32'haaaa_aaaa);
    send_request(32'haaaa_aaaa, 32'h5555_5555);
    send_request(32'd1_000_000_000, 32'd65_103);    // one below slowest rate
    send_request(32'd1_000_000_000, 32'd65_104);
    send_request(32'd3, 32'hffff_ffff);

    for (int k = 0; k < RandomReqs; k++) begin
      if (k == RandomReqs / 3) begin
        sender_gap_pct = 46;
        recv_stall_pct = 10;
      end else if (k == 2 * RandomReqs / 3) begin
        sender_gap_pct = 0;
        recv_stall_pct = 0;
      end
      send_random_request();
    end
    in_valid <= 1'b0;

    while (sb.expected_choices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
